// ----- design/pt_pkg.sv -----
// ----------------------------------------------------------------------------
// pt_pkg
// Shared types, constants and the color blend function for the palette tint
// generator.
// ----------------------------------------------------------------------------
package pt_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;

    localparam int COLOR_W = 16;
    localparam int INDEX_W = 8;
    localparam int TC_W    = 8;
    // tint_count + 1 and the palette depth both fit in this width
    localparam int DIV_W   = TC_W + 1;

    localparam logic [COLOR_W-1:0] RED_MASK = 16'h7c00;
    localparam logic [COLOR_W-1:0] GRN_MASK = 16'h03e0;
    localparam logic [COLOR_W-1:0] BLU_MASK = 16'h001f;
    localparam int GRN_LSB_POS = 15;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_TINT  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic {
        ST_DONE  = 1'b0,
        ST_RANGE = 1'b1
    } t_status;

    typedef logic [COLOR_W-1:0] t_color;

    // Per-channel (a + b) >> 1; green is six bits, its LSB in bit 15.
    function automatic t_color blend_half(input t_color a, input t_color b);
        logic [4:0] ra, rb, ba, bb;
        logic [5:0] ga, gb;
        logic [5:0] rs, bs;
        logic [6:0] gs;
        t_color     v;
        ra = 5'((a & RED_MASK) >> 10);
        rb = 5'((b & RED_MASK) >> 10);
        ga = {5'((a & GRN_MASK) >> 5), a[GRN_LSB_POS]};
        gb = {5'((b & GRN_MASK) >> 5), b[GRN_LSB_POS]};
        ba = 5'(a & BLU_MASK);
        bb = 5'(b & BLU_MASK);
        rs = {1'b0, ra} + {1'b0, rb};
        gs = {1'b0, ga} + {1'b0, gb};
        bs = {1'b0, ba} + {1'b0, bb};
        v  = {gs[1], rs[5:1], gs[6:2], bs[5:1]};
        return v;
    endfunction

endpackage

// ----- design/pt_ram.sv -----
// ----------------------------------------------------------------------------
// pt_ram
// Palette store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pt_ram #(
    parameter int DEPTH  = pt_pkg::PALETTE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [ADDR_W-1:0]          i_waddr,
    input  logic [pt_pkg::COLOR_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]          i_raddr,
    output logic [pt_pkg::COLOR_W-1:0] o_rdata
);
    import pt_pkg::*;

    t_color r_mem [DEPTH];
    t_color r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/pt_div.sv -----
// ----------------------------------------------------------------------------
// pt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pt_div #(
    parameter int W = pt_pkg::DIV_W
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient
);
    import pt_pkg::*;

    localparam int CNT_W = $clog2(W + 1);

    logic [W:0]       r_rem, n_rem;
    logic [W-1:0]     r_quo, n_quo;
    logic [W-1:0]     r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [W:0] rem_sh;

    always_comb begin
        rem_sh = {r_rem[W-1:0], r_quo[W-1]};
        if (rem_sh >= {1'b0, r_dvs}) begin
            n_rem = rem_sh - {1'b0, r_dvs};
            n_quo = {r_quo[W-2:0], 1'b1};
        end else begin
            n_rem = rem_sh;
            n_quo = {r_quo[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- design/palette_tint_generator_core.sv -----
// ----------------------------------------------------------------------------
// palette_tint_generator_core
// Palette of 16-bit G-RGB1555 colors with write, read and 50% tint region
// generation.
//
//   channel  | dir | contents
//   ---------+-----+--------------------------------------------------
//   s stream | in  | tuser: opcode; tdata: index, color
//   m stream | out | tuser: status; tdata: read_data
//   cfg      | in  | tint_count, write enable + data
//
// Word sequence, accept to next accept with m tready high: write, no-op and
// out-of-range tint go from idle to done; read also passes the RAM data state
// (registered RAM read). Tint: DIV_W divider steps plus its done strobe, multiply,
// first read, then one entry per cycle over the RAM's read and write ports.
// One word in flight; s tready only in idle. A result waits in the output
// register while m tready is low. Synchronous active-low reset.
// ----------------------------------------------------------------------------
module palette_tint_generator_core #(
    parameter int PALETTE_DEPTH = pt_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // [7:0] index, [23:8] color
    input  logic [23:0]                i_s_tdata,
    // [1:0] opcode
    input  logic [1:0]                 i_s_tuser,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // [15:0] read_data
    output logic [15:0]                o_m_tdata,
    // [0] status
    output logic                       o_m_tuser,
    input  logic                       i_cfg_we,
    input  logic [pt_pkg::TC_W-1:0]    i_cfg_wdata
);
    import pt_pkg::*;

    localparam int ADDR_W = $clog2(PALETTE_DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int MOD_W  = INDEX_W + 4;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RDATA = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_TRD   = 7'b0010000,
        S_TWR   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    // index modulo depth: idx < 16 * depth, four compare-subtract steps
    function automatic logic [ADDR_W-1:0] mod_depth(input logic [INDEX_W-1:0] idx);
        logic [MOD_W-1:0] v;
        logic [MOD_W-1:0] d;
        v = MOD_W'(idx);
        for (int k = 3; k >= 0; k--) begin
            d = MOD_W'(PALETTE_DEPTH) << k;
            if (v >= d) begin
                v = v - d;
            end
        end
        return v[ADDR_W-1:0];
    endfunction

    t_state              r_state;
    logic [TC_W-1:0]     r_tc;
    logic [INDEX_W-1:0]  r_idx;
    t_color              r_color;
    logic [CNT_W-1:0]    r_interval;
    logic [CNT_W-1:0]    r_base;
    logic [CNT_W-1:0]    r_cnt;
    t_color              r_res_data;
    t_status             r_res_status;
    logic                r_out_valid;
    t_color              r_out_data;
    t_status             r_out_status;

    t_op                 in_op;
    logic [INDEX_W-1:0]  in_idx;
    t_color              in_color;
    logic                in_acc;
    logic                tint_ok;

    logic                div_start;
    logic                div_done;
    logic [DIV_W-1:0]    div_quo;
    logic [INDEX_W+CNT_W:0] prod;
    logic [CNT_W-1:0]    cnt_nxt;
    logic [CNT_W-1:0]    dst;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    t_color              mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;
    t_color              mem_rdata;

    assign in_op    = t_op'(i_s_tuser);
    assign in_idx   = i_s_tdata[7:0];
    assign in_color = i_s_tdata[23:8];
    assign o_s_tready = (r_state == S_IDLE);
    assign in_acc   = i_s_tvalid && o_s_tready;
    assign tint_ok  = (in_idx < r_tc);

    assign div_start = in_acc && (in_op == OP_TINT) && tint_ok;
    assign prod      = ({1'b0, r_idx} + 1'b1) * r_interval;
    assign cnt_nxt   = r_cnt + 1'b1;
    assign dst       = r_base + r_cnt;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = mod_depth(in_idx);
        mem_wdata = in_color;
        mem_raddr = mod_depth(in_idx);
        unique case (r_state)
            S_IDLE: begin
                mem_we = in_acc && (in_op == OP_WRITE);
            end
            S_TRD: begin
                mem_raddr = r_cnt[ADDR_W-1:0];
            end
            S_TWR: begin
                mem_we    = 1'b1;
                mem_waddr = dst[ADDR_W-1:0];
                mem_wdata = blend_half(mem_rdata, r_color);
                mem_raddr = cnt_nxt[ADDR_W-1:0];
            end
            default: begin
            end
        endcase
    end

    pt_ram #(
        .DEPTH  (PALETTE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    pt_div #(
        .W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (DIV_W'(PALETTE_DEPTH)),
        .i_divisor  ({1'b0, r_tc} + 1'b1),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tc        <= TC_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tc <= i_cfg_wdata;
            end
            if (r_state == S_DONE && (!r_out_valid || i_m_tready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (in_op)
                            OP_READ:  r_state <= S_RDATA;
                            OP_TINT:  r_state <= tint_ok ? S_DIV : S_DONE;
                            default:  r_state <= S_DONE;
                        endcase
                    end
                end
                S_RDATA: r_state <= S_DONE;
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= (r_interval == '0) ? S_DONE : S_TRD;
                S_TRD: r_state <= S_TWR;
                S_TWR: begin
                    if (cnt_nxt == r_interval) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload path
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_idx        <= in_idx;
            r_color      <= in_color;
            r_res_data   <= '0;
            r_res_status <= (in_op == OP_TINT && !tint_ok) ? ST_RANGE : ST_DONE;
        end
        if (r_state == S_RDATA) begin
            r_res_data <= mem_rdata;
        end
        if (r_state == S_DIV && div_done) begin
            r_interval <= div_quo[CNT_W-1:0];
        end
        if (r_state == S_MUL) begin
            r_base <= prod[CNT_W-1:0];
            r_cnt  <= '0;
        end
        if (r_state == S_TWR) begin
            r_cnt <= cnt_nxt;
        end
        if (r_state == S_DONE && (!r_out_valid || i_m_tready)) begin
            r_out_data   <= r_res_data;
            r_out_status <= r_res_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;

endmodule
